// ===== sv/rtt_rto_estimator_assert.svh =====
`ifndef RTT_RTO_ESTIMATOR_ASSERT_SVH
`define RTT_RTO_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RTE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define RTE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rte_pkg.sv =====
`default_nettype none

package rte_pkg;

  localparam int KIND_W     = 2;
  localparam int SAMPLE_W   = 32;
  localparam int RTO_W      = 32;
  localparam int EST_W      = 31;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 1;

  localparam int TIME_BITS_DEFAULT = 32;

  localparam logic [RTO_W-1:0] MIN_RTO_RESET = 32'd1000000;
  localparam logic [RTO_W-1:0] MAX_RTO_RESET = 32'd60000000;
  localparam logic [RTO_W-1:0] CLOCK_GRAIN   = 32'd1000;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_TIMEOUT = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_RTO = 1'b0,
    REG_MAX_RTO = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic signed [SAMPLE_W-1:0] rtt_sample;
  } item_t;

  typedef struct packed {
    logic [RTO_W-1:0] min_rto;
    logic [RTO_W-1:0] max_rto;
  } cfg_t;

  typedef struct packed {
    logic [RTO_W-1:0] rto;
    logic [EST_W-1:0] smoothed_rtt;
    logic [EST_W-1:0] rtt_variance;
    logic             sample_rejected;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/rte_if.sv =====
`default_nettype none

interface rte_in_if;
  logic                                valid;
  logic                                ready;
  logic [rte_pkg::KIND_W-1:0]          kind;
  logic signed [rte_pkg::SAMPLE_W-1:0] rtt_sample;

  modport source (output valid, output kind, output rtt_sample, input ready);
  modport sink (input valid, input kind, input rtt_sample, output ready);
endinterface

interface rte_out_if;
  logic                       valid;
  logic                       ready;
  logic [rte_pkg::RTO_W-1:0]  rto;
  logic [rte_pkg::EST_W-1:0]  smoothed_rtt;
  logic [rte_pkg::EST_W-1:0]  rtt_variance;
  logic                       sample_rejected;

  modport source (output valid, output rto, output smoothed_rtt, output rtt_variance,
                  output sample_rejected, input ready);
  modport sink (input valid, input rto, input smoothed_rtt, input rtt_variance,
                input sample_rejected, output ready);
endinterface

`default_nettype wire

// ===== sv/rte_core.sv =====
`default_nettype none
`include "rtt_rto_estimator_assert.svh"

module rte_core #(
  parameter int TIME_BITS = rte_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             commit,
  input  wire rte_pkg::item_t   item,
  input  wire rte_pkg::cfg_t    cfg,
  output rte_pkg::result_t      result
);

  // srtt and rttvar never exceed min(2^31-1, time max)
  localparam int SRTT_W = (TIME_BITS < 31) ? TIME_BITS : 31;
  localparam int WIDE   = ((TIME_BITS > 32) ? TIME_BITS : 32) + 3;
  localparam logic [30:0]     S_MAX    = 31'((64'd1 << SRTT_W) - 64'd1);
  localparam logic [WIDE-1:0] TIME_MAX = WIDE'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [WIDE-1:0] GRAIN    = WIDE'(rte_pkg::CLOCK_GRAIN);

  logic [SRTT_W-1:0]         srtt;
  logic [SRTT_W-1:0]         srtt_next;
  logic [SRTT_W-1:0]         rttvar;
  logic [SRTT_W-1:0]         rttvar_next;
  logic [rte_pkg::RTO_W-1:0] rto;
  logic [rte_pkg::RTO_W-1:0] rto_next;
  logic                      have_sample;
  logic                      have_sample_next;

  logic              bad_sample;
  logic [SRTT_W-1:0] s_val;
  logic [SRTT_W-1:0] diff;
  logic [SRTT_W+1:0] var_sum;
  logic [SRTT_W+2:0] srtt_sum;
  logic [SRTT_W-1:0] srtt_upd;
  logic [SRTT_W-1:0] rttvar_upd;
  logic [WIDE-1:0]   spread;
  logic [WIDE-1:0]   rto_raw;
  logic [WIDE-1:0]   rto_lo;
  logic [WIDE-1:0]   rto_hi;
  logic [WIDE-1:0]   dbl_raw;
  logic [WIDE-1:0]   dbl_sat;
  logic [rte_pkg::RTO_W-1:0] rto_sample;
  logic [rte_pkg::RTO_W-1:0] rto_backoff;

  always_comb begin
    bad_sample = (item.rtt_sample == '0) || item.rtt_sample[31];
    s_val = (item.rtt_sample[30:0] > S_MAX) ? SRTT_W'(S_MAX) : SRTT_W'(item.rtt_sample[30:0]);

    // smoothing uses the old srtt for the deviation
    diff     = (srtt >= s_val) ? (srtt - s_val) : (s_val - srtt);
    var_sum  = {2'b00, rttvar} + {1'b0, rttvar, 1'b0} + {2'b00, diff};
    srtt_sum = {srtt, 3'b000} - {3'b000, srtt} + {3'b000, s_val};

    if (have_sample) begin
      srtt_upd   = srtt_sum[SRTT_W+2:3];
      rttvar_upd = var_sum[SRTT_W+1:2];
    end else begin
      srtt_upd   = s_val;
      rttvar_upd = s_val >> 1;
    end

    spread = WIDE'({rttvar_upd, 2'b00});
    if (spread < GRAIN) begin
      spread = GRAIN;
    end
    rto_raw = WIDE'(srtt_upd) + spread;
    if (rto_raw > TIME_MAX) begin
      rto_raw = TIME_MAX;
    end
    rto_lo = (rto_raw < WIDE'(cfg.min_rto)) ? WIDE'(cfg.min_rto) : rto_raw;
    rto_hi = (rto_lo > WIDE'(cfg.max_rto)) ? WIDE'(cfg.max_rto) : rto_lo;
    rto_sample = rto_hi[rte_pkg::RTO_W-1:0];

    dbl_raw = WIDE'({rto, 1'b0});
    dbl_sat = (dbl_raw > TIME_MAX) ? TIME_MAX : dbl_raw;
    rto_backoff = (dbl_sat > WIDE'(cfg.max_rto)) ? cfg.max_rto
                                                 : dbl_sat[rte_pkg::RTO_W-1:0];
  end

  always_comb begin
    srtt_next        = srtt;
    rttvar_next      = rttvar;
    rto_next         = rto;
    have_sample_next = have_sample;
    result.sample_rejected = 1'b0;
    case (rte_pkg::kind_t'(item.kind))
      rte_pkg::KIND_SAMPLE: begin
        if (bad_sample) begin
          result.sample_rejected = 1'b1;
        end else begin
          srtt_next        = srtt_upd;
          rttvar_next      = rttvar_upd;
          rto_next         = rto_sample;
          have_sample_next = 1'b1;
        end
      end
      rte_pkg::KIND_TIMEOUT: begin
        rto_next = rto_backoff;
      end
      rte_pkg::KIND_RESTART: begin
        srtt_next        = '0;
        rttvar_next      = '0;
        rto_next         = cfg.min_rto;
        have_sample_next = 1'b0;
      end
      default: begin
      end
    endcase
    result.rto          = rto_next;
    result.smoothed_rtt = rte_pkg::EST_W'(srtt_next);
    result.rtt_variance = rte_pkg::EST_W'(rttvar_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      srtt        <= '0;
      rttvar      <= '0;
      rto         <= rte_pkg::MIN_RTO_RESET;
      have_sample <= 1'b0;
    end else if (commit) begin
      srtt        <= srtt_next;
      rttvar      <= rttvar_next;
      rto         <= rto_next;
      have_sample <= have_sample_next;
    end
  end

  `RTE_ASSERT_NEXT(a_reject_keeps_state, commit && result.sample_rejected,
    $stable(srtt) && $stable(rttvar) && $stable(rto), "rejected sample changed state")
  `RTE_ASSERT_NOW(a_empty_is_zero, !have_sample,
    (srtt == '0) && (rttvar == '0), "estimates nonzero without a sample")
  `RTE_ASSERT_NEXT(a_restart_rto, commit && (item.kind == rte_pkg::KIND_RESTART),
    (rto == $past(cfg.min_rto)) && !have_sample, "restart did not load min_rto")
  `RTE_ASSERT_NEXT(a_sample_ceiling,
    commit && (item.kind == rte_pkg::KIND_SAMPLE) && !bad_sample,
    (rto <= $past(cfg.max_rto)) && have_sample, "rto above max_rto after sample")

endmodule

`default_nettype wire

// ===== sv/rtt_rto_estimator.sv =====
// RTT / RTO estimator.
// item channel (valid/ready): one event per transaction; kind 0 carries an RTT
//   sample in microseconds, kind 1 is a retransmit timeout (rto doubles,
//   capped at max_rto), kind 2 restarts the estimator (rto = min_rto).
// result channel (valid/ready): exactly one transaction per event, in order,
//   with rto, smoothed rtt, rtt variance and a flag for a dropped sample.
// cfg port: cfg_write with cfg_index 0 writes min_rto, 1 writes max_rto;
//   write only while no event is in flight. rto is not recomputed on write.
// An accepted event waits in the event register; its result is then
//   registered in the result register. Throughput: one event per cycle while
//   the result channel does not stall; the whole update is one combinational
//   pass from the event register and estimator state to the result register.
// A stalled result holds in the result register while one more event waits
//   in the event register; item.ready drops only when both are full.
// Reset (rst, synchronous): estimates cleared, rto = 1000000, min_rto =
//   1000000, max_rto = 60000000, both stages empty.
`default_nettype none
`include "rtt_rto_estimator_assert.svh"

module rtt_rto_estimator #(
  parameter int TIME_BITS = rte_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [rte_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [rte_pkg::CFG_DATA_W-1:0]    cfg_data,
  rte_in_if.sink                                 item,
  rte_out_if.source                              result
);

  rte_pkg::cfg_t    cfg;
  rte_pkg::item_t   in_data;
  logic             in_valid;
  rte_pkg::result_t out_data;
  logic             out_valid;
  rte_pkg::result_t core_result;
  logic             advance;

  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_rto <= rte_pkg::MIN_RTO_RESET;
      cfg.max_rto <= rte_pkg::MAX_RTO_RESET;
    end else if (cfg_write) begin
      case (rte_pkg::cfg_reg_t'(cfg_index))
        rte_pkg::REG_MIN_RTO: cfg.min_rto <= cfg_data;
        rte_pkg::REG_MAX_RTO: cfg.max_rto <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_data.kind       <= item.kind;
      in_data.rtt_sample <= item.rtt_sample;
    end
  end

  rte_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (in_data),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= core_result;
    end
  end

  assign result.valid           = out_valid;
  assign result.rto             = out_data.rto;
  assign result.smoothed_rtt    = out_data.smoothed_rtt;
  assign result.rtt_variance    = out_data.rtt_variance;
  assign result.sample_rejected = out_data.sample_rejected;

  `RTE_ASSERT_NOW(a_full_blocks_input, in_valid && out_valid && !result.ready,
    !item.ready, "event accepted with both stages full")
  `RTE_ASSERT_NEXT(a_advance_fills_output, advance,
    out_valid, "advanced event did not reach the result register")

endmodule

`default_nettype wire
